// ----- hw/rtl/pps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the priority scheduler
// Widths of the descriptor and result fields, the controller/datapath
// command and status groups, and the store sizing.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ARR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int BUR_W  = 16;
  localparam int PIDX_W = 6;
  localparam int TICK_W = 23;
  localparam int SUM_W  = 29;

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [PRI_W-1:0] priority_level;
    logic [BUR_W-1:0] burst_length;
    logic             last_process;
  } in_req_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TICK_W-1:0] finish_time;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              last_result;
  } out_res_t;

  // One stored descriptor.
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [PRI_W-1:0] prio;
    logic [BUR_W-1:0] burst;
  } desc_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;       // store the accepted descriptor
    logic             scan_start; // clear the scan accumulators
    logic             scan_rd;    // read entry scan_addr for evaluation
    logic [IDX_W-1:0] scan_addr;
    logic             best_rd;    // read the selected entry
    logic             calc_run;   // register the run length
    logic             apply;      // advance time, update remaining burst
    logic             idle_jump;  // move time to the earliest pending arrival
    logic             finish;     // record the completion, load the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             best_valid; // some entry is ready to run
    logic             fin;        // the selected entry completes this run
    logic             last;       // the next completion ends the schedule
    logic             out_free;   // result register can take a result
    logic [CNT_W-1:0] count;      // descriptors loaded
  } dp_sts_t;

endpackage

// ----- hw/rtl/pps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_dp: scheduler datapath
// Descriptor and remaining-burst stores, scan accumulators, time and sum
// registers, and the result register.
// ----------------------------------------------------------------------------
module pps_dp import pps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  input  in_req_t  in_req_i,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output out_res_t out_res_o
);

  desc_t            desc_mem [MAX_PROCS];
  logic [BUR_W-1:0] rem_mem  [MAX_PROCS];

  desc_t            rd_desc_q;
  logic [BUR_W-1:0] rd_rem_q;
  logic             eval_q;
  logic [IDX_W-1:0] eval_idx_q;

  logic [CNT_W-1:0]     count_q, fin_cnt_q;
  logic [TICK_W-1:0]    tick_q, tat_q;
  logic [SUM_W-1:0]     sum_t_q, sum_w_q;
  logic [MAX_PROCS-1:0] done_q;

  logic             best_valid_q, fut_valid_q;
  logic [IDX_W-1:0] best_q;
  logic [PRI_W-1:0] best_prio_q;
  logic [ARR_W-1:0] fut_min_q;
  logic [BUR_W-1:0] run_q;

  logic     out_valid_q;
  out_res_t out_q;

  logic             full, arrived, pending, take_best, take_fut, fin, last, out_free;
  logic [IDX_W-1:0] ld_idx, rd_addr;
  logic [BUR_W-1:0] ld_burst, gap, run_d;
  logic [TICK_W-1:0] gap_w, wt;
  logic             clear;

  assign full     = (count_q == CNT_W'(MAX_PROCS));
  assign ld_idx   = count_q[IDX_W-1:0];
  assign ld_burst = (in_req_i.burst_length == '0) ? BUR_W'(1) : in_req_i.burst_length;
  assign rd_addr  = cmd_i.scan_rd ? cmd_i.scan_addr : best_q;

  // Store writes: load fills a fresh entry, apply updates remaining burst.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      desc_mem[ld_idx] <= '{arrival: in_req_i.arrival_time,
                            prio:    in_req_i.priority_level,
                            burst:   ld_burst};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      rem_mem[ld_idx] <= ld_burst;
    end else if (cmd_i.apply) begin
      rem_mem[best_q] <= rd_rem_q - run_q;
    end
  end

  // Registered read port shared by the scan and the selected entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd || cmd_i.best_rd) begin
      rd_desc_q <= desc_mem[rd_addr];
      rd_rem_q  <= rem_mem[rd_addr];
    end
  end

  // Scan evaluation of the entry read in the previous cycle.
  assign pending   = eval_q && !done_q[eval_idx_q];
  assign arrived   = (TICK_W'(rd_desc_q.arrival) <= tick_q);
  assign take_best = pending && arrived &&
                     (!best_valid_q || (rd_desc_q.prio > best_prio_q));
  assign take_fut  = pending && !arrived &&
                     (!fut_valid_q || (rd_desc_q.arrival < fut_min_q));

  // Run until completion or the next arrival, whichever comes first.
  assign gap_w = TICK_W'(fut_min_q) - tick_q;
  assign gap   = gap_w[BUR_W-1:0];
  assign run_d = (fut_valid_q && (gap < rd_rem_q)) ? gap : rd_rem_q;

  assign fin      = (rd_rem_q == run_q);
  assign last     = ((fin_cnt_q + CNT_W'(1)) == count_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign wt       = tat_q - TICK_W'(rd_desc_q.burst);
  assign clear    = cmd_i.finish && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q       <= 1'b0;
      count_q      <= '0;
      fin_cnt_q    <= '0;
      tick_q       <= '0;
      sum_t_q      <= '0;
      sum_w_q      <= '0;
      done_q       <= '0;
      best_valid_q <= 1'b0;
      fut_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      eval_q <= cmd_i.scan_rd;
      if (cmd_i.load && !full) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        best_valid_q <= 1'b0;
        fut_valid_q  <= 1'b0;
      end else begin
        if (take_best) best_valid_q <= 1'b1;
        if (take_fut)  fut_valid_q  <= 1'b1;
      end
      if (cmd_i.idle_jump) begin
        tick_q <= TICK_W'(fut_min_q);
      end else if (cmd_i.apply) begin
        tick_q <= tick_q + TICK_W'(run_q);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (last) begin
          // End of schedule: return to an empty batch.
          count_q      <= '0;
          fin_cnt_q    <= '0;
          tick_q       <= '0;
          sum_t_q      <= '0;
          sum_w_q      <= '0;
          done_q       <= '0;
          best_valid_q <= 1'b0;
        end else begin
          fin_cnt_q      <= fin_cnt_q + CNT_W'(1);
          sum_t_q        <= sum_t_q + SUM_W'(tat_q);
          sum_w_q        <= sum_w_q + SUM_W'(wt);
          done_q[best_q] <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    eval_idx_q <= cmd_i.scan_addr;
    if (take_best) begin
      best_q      <= eval_idx_q;
      best_prio_q <= rd_desc_q.prio;
    end
    if (take_fut) begin
      fut_min_q <= rd_desc_q.arrival;
    end
    if (cmd_i.calc_run) begin
      run_q <= run_d;
    end
    if (cmd_i.apply) begin
      tat_q <= tick_q + TICK_W'(run_q) - TICK_W'(rd_desc_q.arrival);
    end
    if (cmd_i.finish) begin
      out_q.process_index    <= PIDX_W'(best_q);
      out_q.finish_time      <= tick_q;
      out_q.turnaround       <= tat_q;
      out_q.waiting          <= wt;
      out_q.total_turnaround <= sum_t_q + SUM_W'(tat_q);
      out_q.total_waiting    <= sum_w_q + SUM_W'(wt);
      out_q.last_result      <= last;
    end
  end

  assign sts_o = '{best_valid: best_valid_q, fin: fin, last: last,
                   out_free: out_free, count: count_q};
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> out_free)
    else $error("result loaded while the result register is held");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PROCS))
    else $error("loaded count beyond store depth");

  a_time_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear |=> (tick_q >= $past(tick_q)))
    else $error("schedule time moved backward");

  a_best_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_valid_q |-> (CNT_W'(best_q) < count_q))
    else $error("selected entry lies beyond the loaded descriptors");

endmodule

// ----- hw/rtl/pps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl: scheduler controller
// Sequences loading, the per-decision scan of the stores, the run update
// and the hand-off of each completion to the result register.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DECIDE,
    S_RUN,
    S_APPLY,
    S_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic             in_accept, scan_end;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign scan_end   = (CNT_W'(scan_idx_q) == (sts_i.count - CNT_W'(1)));

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    cmd_o      = '0;
    cmd_o.scan_addr = scan_idx_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_accept;
        scan_idx_d = '0;
        if (in_accept && in_last_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd    = 1'b1;
        cmd_o.scan_start = (scan_idx_q == '0);
        if (scan_end) begin
          state_d    = S_TAIL;
          scan_idx_d = '0;
        end else begin
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end
      end
      S_TAIL: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.best_valid) begin
          cmd_o.best_rd = 1'b1;
          state_d       = S_RUN;
        end else begin
          cmd_o.idle_jump = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_RUN: begin
        cmd_o.calc_run = 1'b1;
        state_d        = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.fin ? S_FINISH : S_SCAN;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = sts_i.last ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
    end
  end

  a_scan_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) && (state_d == S_SCAN) |=> (scan_idx_q == '0))
    else $error("scan did not start at the first entry");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(scan_idx_q) < sts_i.count))
    else $error("scan address beyond the loaded descriptors");

  a_tail_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |-> ($past(state_q) == S_SCAN))
    else $error("scan drain entered without a scan");

endmodule

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: preemptive priority scheduling engine
// Loads process descriptors and, on the closing one, runs the schedule and
// streams one completion result per process.
// ----------------------------------------------------------------------------
// A descriptor request is taken whenever the block is loading, and up to
// MAX_PROCS descriptors are stored; further ones are dropped, though a
// dropped closing descriptor still starts the schedule. The request marked
// last_process holds the input stalled until the whole schedule has run.
// The schedule advances decision by decision: each decision scans the n
// stored entries through the single read port of the stores, then either
// jumps time to the earliest pending arrival, or runs the chosen process
// until it completes or the next arrival comes and, on completion, loads
// the result register once it is no longer held. Results leave in
// completion order; the last one carries last_result, after which the
// block is ready for a new batch.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_res_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: owns the sequence and the input stall.
  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_req_i.last_process),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: stores, scan accumulators, time, sums and result register.
  pps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule
